// ===== hw/rtl/ncbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncbe_pkg: shared types and constants of the neighbor cell bucket enumerator
// Field widths, register reset, sequencer states, offset codes and the
// result item structure.
// ----------------------------------------------------------------------------
package ncbe_pkg;

  // fixed field widths
  localparam int unsigned POS_FIELD_W = 16;
  localparam int unsigned INV_W       = 16;
  localparam int unsigned CELL_IDX_W  = 8;   // integer part of the Q8.8 register
  localparam int unsigned BUCKET_W    = 15;
  localparam int unsigned COUNT_W     = 5;

  localparam int unsigned S_TDATA_W   = 3 * POS_FIELD_W;
  localparam int unsigned M_TDATA_W   = 24;  // bucket + count, padded to bytes

  localparam logic [INV_W-1:0] INV_RESET = 16'd2560;

  // parameter defaults
  localparam int unsigned CELL_BITS_DEF = 5;
  localparam int unsigned POS_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_X,
    ST_CELL_Y,
    ST_CELL_Z,
    ST_CELL_FIN,
    ST_WALK
  } state_e;

  // offset of one axis: -1, 0, +1
  typedef enum logic [1:0] {
    OFF_NEG,
    OFF_ZERO,
    OFF_POS
  } off_e;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic                last;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

endpackage

// ===== hw/rtl/ncbe_cell_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncbe_cell_mul: shared cell index multiplier
// Registered product of one coordinate and the inverse cell size, keeping the
// integer bits: cell = floor(pos * inv / 2^(POS_BITS+8)).
// ----------------------------------------------------------------------------
module ncbe_cell_mul #(
  parameter int unsigned POS_BITS = ncbe_pkg::POS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic [POS_BITS-1:0]             pos_i,
  input  logic [ncbe_pkg::INV_W-1:0]      inv_i,
  output logic [ncbe_pkg::CELL_IDX_W-1:0] cell_o
);

  localparam int unsigned ProdW = POS_BITS + ncbe_pkg::INV_W;

  logic [ProdW-1:0]                prod;
  logic [ncbe_pkg::CELL_IDX_W-1:0] cell_d, cell_q;

  assign prod   = ProdW'(pos_i) * ProdW'(inv_i);
  assign cell_d = prod[ProdW-1 -: ncbe_pkg::CELL_IDX_W];

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== hw/rtl/ncbe_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncbe_seq: cell sequencer and neighbor walker
// Feeds the three axes through the shared multiplier, then gives the home bucket
// or walks the 27 offsets (z outer, x inner), skips cells outside the grid and
// registers one Morton bucket per remaining cell.
// ----------------------------------------------------------------------------
module ncbe_seq #(
  parameter int unsigned CELL_BITS = ncbe_pkg::CELL_BITS_DEF,
  parameter int unsigned POS_BITS  = ncbe_pkg::POS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_action_i,
  input  logic [POS_BITS-1:0]             in_pos_x_i,
  input  logic [POS_BITS-1:0]             in_pos_y_i,
  input  logic [POS_BITS-1:0]             in_pos_z_i,
  input  logic [ncbe_pkg::CELL_IDX_W-1:0] max_idx_i,
  output logic [POS_BITS-1:0]             mul_pos_o,
  input  logic [ncbe_pkg::CELL_IDX_W-1:0] mul_cell_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ncbe_pkg::out_item_t             out_item_o
);

  localparam int unsigned IdxW    = ncbe_pkg::CELL_IDX_W;
  localparam int unsigned CellExtW = (CELL_BITS > IdxW) ? CELL_BITS : IdxW;
  localparam int unsigned BucketW = ncbe_pkg::BUCKET_W;
  localparam int unsigned CountW  = ncbe_pkg::COUNT_W;

  ncbe_pkg::state_e state_q, state_d;
  ncbe_pkg::off_e   dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  ncbe_pkg::off_e   last_x, last_y, last_z;

  logic [POS_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic                action_q;
  logic [IdxW-1:0]     cx_q, cy_q, cz_q;
  logic [CountW-1:0]   n_q, n_d;
  logic                out_valid_q, out_valid_d;
  ncbe_pkg::out_item_t item_q, item_d;

  logic            accept, slot_free, home_mode, nb_valid, is_done;
  logic            walk_step, emit;
  logic [IdxW-1:0] nx, ny, nz;
  logic [CellExtW-1:0] ex, ey, ez;
  logic [BucketW-1:0]  bucket;

  function automatic logic [IdxW-1:0] off_apply(logic [IdxW-1:0] c, ncbe_pkg::off_e o);
    logic [IdxW-1:0] r;
    case (o)
      ncbe_pkg::OFF_NEG: r = c - IdxW'(1);
      ncbe_pkg::OFF_POS: r = c + IdxW'(1);
      default:           r = c;
    endcase
    return r;
  endfunction

  function automatic logic off_ok(logic [IdxW-1:0] c, ncbe_pkg::off_e o,
                                  logic [IdxW-1:0] mx);
    logic ok;
    case (o)
      ncbe_pkg::OFF_NEG: ok = (c != '0);
      ncbe_pkg::OFF_POS: ok = (c != mx);
      default:           ok = 1'b1;
    endcase
    return ok;
  endfunction

  assign in_ready_o = (state_q == ncbe_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign home_mode  = !action_q;

  // the home cell never exceeds max, so the final valid offset per axis is known
  assign last_x = (cx_q == max_idx_i) ? ncbe_pkg::OFF_ZERO : ncbe_pkg::OFF_POS;
  assign last_y = (cy_q == max_idx_i) ? ncbe_pkg::OFF_ZERO : ncbe_pkg::OFF_POS;
  assign last_z = (cz_q == max_idx_i) ? ncbe_pkg::OFF_ZERO : ncbe_pkg::OFF_POS;

  assign nb_valid = off_ok(cx_q, dx_q, max_idx_i) && off_ok(cy_q, dy_q, max_idx_i) &&
                    off_ok(cz_q, dz_q, max_idx_i);
  assign is_done  = home_mode || (dx_q == last_x && dy_q == last_y && dz_q == last_z);

  assign nx = home_mode ? cx_q : off_apply(cx_q, dx_q);
  assign ny = home_mode ? cy_q : off_apply(cy_q, dy_q);
  assign nz = home_mode ? cz_q : off_apply(cz_q, dz_q);

  assign ex = CellExtW'(nx);
  assign ey = CellExtW'(ny);
  assign ez = CellExtW'(nz);

  // Morton interleave, x in the lowest bit of each triple
  always_comb begin
    bucket = '0;
    for (int unsigned i = 0; i < CELL_BITS; i++) begin
      if (3 * i < BucketW)     bucket[3 * i]     = ex[i];
      if (3 * i + 1 < BucketW) bucket[3 * i + 1] = ey[i];
      if (3 * i + 2 < BucketW) bucket[3 * i + 2] = ez[i];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ncbe_pkg::ST_IDLE:     if (in_valid_i) state_d = ncbe_pkg::ST_CELL_X;
      ncbe_pkg::ST_CELL_X:   state_d = ncbe_pkg::ST_CELL_Y;
      ncbe_pkg::ST_CELL_Y:   state_d = ncbe_pkg::ST_CELL_Z;
      ncbe_pkg::ST_CELL_Z:   state_d = ncbe_pkg::ST_CELL_FIN;
      ncbe_pkg::ST_CELL_FIN: state_d = ncbe_pkg::ST_WALK;
      ncbe_pkg::ST_WALK:     if (slot_free && is_done) state_d = ncbe_pkg::ST_IDLE;
      default:               state_d = ncbe_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_pos_o = pos_x_q;
    walk_step = 1'b0;
    emit      = 1'b0;
    case (state_q)
      ncbe_pkg::ST_CELL_X: mul_pos_o = pos_x_q;
      ncbe_pkg::ST_CELL_Y: mul_pos_o = pos_y_q;
      ncbe_pkg::ST_CELL_Z: mul_pos_o = pos_z_q;
      ncbe_pkg::ST_WALK: begin
        walk_step = slot_free;
        emit      = slot_free && (home_mode || nb_valid);
      end
      default: begin
        mul_pos_o = pos_x_q;
      end
    endcase
  end

  // offset counter: x fastest, then y, then z
  always_comb begin
    dx_d = dx_q;
    dy_d = dy_q;
    dz_d = dz_q;
    if (state_q == ncbe_pkg::ST_CELL_FIN) begin
      dx_d = ncbe_pkg::OFF_NEG;
      dy_d = ncbe_pkg::OFF_NEG;
      dz_d = ncbe_pkg::OFF_NEG;
    end else if (walk_step) begin
      if (dx_q != ncbe_pkg::OFF_POS) begin
        dx_d = ncbe_pkg::off_e'(dx_q + 2'd1);
      end else begin
        dx_d = ncbe_pkg::OFF_NEG;
        if (dy_q != ncbe_pkg::OFF_POS) begin
          dy_d = ncbe_pkg::off_e'(dy_q + 2'd1);
        end else begin
          dy_d = ncbe_pkg::OFF_NEG;
          dz_d = ncbe_pkg::off_e'(dz_q + 2'd1);
        end
      end
    end
  end

  always_comb begin
    n_d         = n_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (state_q == ncbe_pkg::ST_CELL_FIN) n_d = '0;
    if (emit) begin
      n_d           = n_q + CountW'(1);
      out_valid_d   = 1'b1;
      item_d.bucket = bucket;
      item_d.last   = is_done;
      item_d.count  = is_done ? n_q + CountW'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ncbe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      dx_q        <= ncbe_pkg::OFF_NEG;
      dy_q        <= ncbe_pkg::OFF_NEG;
      dz_q        <= ncbe_pkg::OFF_NEG;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      dz_q        <= dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_x_q  <= in_pos_x_i;
      pos_y_q  <= in_pos_y_i;
      pos_z_q  <= in_pos_z_i;
      action_q <= in_action_i;
    end
    // multiplier result is registered, so it arrives in the state after its operand
    if (state_q == ncbe_pkg::ST_CELL_Y)   cx_q <= mul_cell_i;
    if (state_q == ncbe_pkg::ST_CELL_Z)   cy_q <= mul_cell_i;
    if (state_q == ncbe_pkg::ST_CELL_FIN) cz_q <= mul_cell_i;
    item_q <= item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = item_q;

  a_last_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && item_q.last |-> item_q.count != '0)
    else $error("final item carries zero count");

  a_count_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !item_q.last |-> item_q.count == '0)
    else $error("count on non-final item");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CountW'(27))
    else $error("more than 27 items for one input");

  a_home_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && home_mode |-> n_q == '0)
    else $error("home mode emitted more than one item");

endmodule

// ===== hw/rtl/neighbor_cell_bucket_enumerator.sv =====
`timescale 1ns / 1ps
// The first result is registered in the walk state, after the cell states CELL_X,
// CELL_Y, CELL_Z and CELL_FIN. Home mode gives one result; neighborhood mode walks
// up to 27 offsets. A new item is accepted only in the idle state, once the
// sequencer has finished the previous one.
// Output stalls hold the walk. Reset clears the sequencer and output valid and
// loads the inverse cell size with 10.0.
// ----------------------------------------------------------------------------
// neighbor_cell_bucket_enumerator: Morton hash buckets of a cell and neighbors
// Maps a unit-box position to its grid cell and gives the home bucket or the
// buckets of all in-grid cells of its 3x3x3 neighborhood.
// ----------------------------------------------------------------------------
module neighbor_cell_bucket_enumerator #(
  parameter int unsigned CELL_BITS = ncbe_pkg::CELL_BITS_DEF,
  parameter int unsigned POS_BITS  = ncbe_pkg::POS_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration: inverse cell size, Q8.8
  input  logic                             cfg_we_i,
  input  logic [ncbe_pkg::INV_W-1:0]       cfg_wdata_i,
  // input items
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ncbe_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,  // pos_x, pos_y, pos_z
  input  logic                             s_axis_tuser_i,  // action
  // result items
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [ncbe_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,  // bucket, bucket_count, pad
  output logic                             m_axis_tlast_o
);

  localparam int unsigned FieldW = ncbe_pkg::POS_FIELD_W;
  localparam int unsigned ExtW   = (POS_BITS > FieldW) ? POS_BITS : FieldW;
  localparam int unsigned PackW  = ncbe_pkg::BUCKET_W + ncbe_pkg::COUNT_W;

  logic [ncbe_pkg::INV_W-1:0] inv_q;
  logic [ExtW-1:0]            ext_x, ext_y, ext_z;
  logic [POS_BITS-1:0]        mul_pos;
  logic [ncbe_pkg::CELL_IDX_W-1:0] mul_cell;
  ncbe_pkg::out_item_t        item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= ncbe_pkg::INV_RESET;
    end else if (cfg_we_i) begin
      inv_q <= cfg_wdata_i;
    end
  end

  // use the low POS_BITS of each coordinate
  assign ext_x = ExtW'(s_axis_tdata_i[FieldW-1:0]);
  assign ext_y = ExtW'(s_axis_tdata_i[2*FieldW-1:FieldW]);
  assign ext_z = ExtW'(s_axis_tdata_i[3*FieldW-1:2*FieldW]);

  ncbe_cell_mul #(
    .POS_BITS (POS_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .pos_i  (mul_pos),
    .inv_i  (inv_q),
    .cell_o (mul_cell)
  );

  ncbe_seq #(
    .CELL_BITS (CELL_BITS),
    .POS_BITS  (POS_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_pos_x_i  (ext_x[POS_BITS-1:0]),
    .in_pos_y_i  (ext_y[POS_BITS-1:0]),
    .in_pos_z_i  (ext_z[POS_BITS-1:0]),
    .max_idx_i   (inv_q[ncbe_pkg::INV_W-1 -: ncbe_pkg::CELL_IDX_W]),
    .mul_pos_o   (mul_pos),
    .mul_cell_i  (mul_cell),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (item)
  );

  assign m_axis_tdata_o = ncbe_pkg::M_TDATA_W'({item.count, item.bucket});
  assign m_axis_tlast_o = item.last;

  // PackW bounds the used part of tdata
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[ncbe_pkg::M_TDATA_W-1:PackW] == '0)
    else $error("tdata padding not zero");

endmodule

// ===== test/ncbe_bucket_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncbe_bucket_checker: bucket prediction and comparison
// Watches the configuration port and both streams of the neighbor cell bucket
// enumerator. Every accepted position is turned into its list of expected
// buckets, and every accepted bucket item is compared with the oldest one.
// ----------------------------------------------------------------------------
module ncbe_bucket_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ncbe_pkg::INV_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [ncbe_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // pos_x, pos_y, pos_z
  input  logic                           s_axis_tuser_i,  // action
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [ncbe_pkg::M_TDATA_W-1:0] m_axis_tdata_i,  // bucket, bucket_count, pad
  input  logic                           m_axis_tlast_i,
  output int                             errors_o,
  output int                             pending_o
);
  import ncbe_pkg::*;

  localparam int unsigned HASH_BITS = CELL_BITS_DEF;

  logic [INV_W-1:0] inv_size_q;
  out_item_t        expected_buckets[$];
  out_item_t        got_item;
  out_item_t        want_item;
  int               mismatch_total = 0;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic logic [CELL_IDX_W-1:0] cell_index(logic [POS_FIELD_W-1:0] pos,
                                                       logic [INV_W-1:0] inv);
    logic [31:0] prod;
    prod = {16'd0, pos} * {16'd0, inv};
    return prod[31:24];
  endfunction

  // interleave masked cell indices, x in the lowest bit of each triple
  function automatic logic [BUCKET_W-1:0] morton_bucket(int cx, int cy, int cz);
    logic [HASH_BITS-1:0] mx, my, mz;
    logic [BUCKET_W-1:0]  r;
    mx = cx[HASH_BITS-1:0];
    my = cy[HASH_BITS-1:0];
    mz = cz[HASH_BITS-1:0];
    r  = '0;
    for (int i = 0; i < HASH_BITS; i++) begin
      r[3*i]   = mx[i];
      r[3*i+1] = my[i];
      r[3*i+2] = mz[i];
    end
    return r;
  endfunction

  function automatic void predict_buckets(logic action, logic [S_TDATA_W-1:0] pos,
                                          logic [INV_W-1:0] inv);
    int        cx, cy, cz, maxi, n;
    out_item_t walk[$];
    out_item_t rec;
    cx   = cell_index(pos[15:0], inv);
    cy   = cell_index(pos[31:16], inv);
    cz   = cell_index(pos[47:32], inv);
    maxi = inv[15:8];
    if (!action) begin
      rec.bucket = morton_bucket(cx, cy, cz);
      rec.last   = 1'b1;
      rec.count  = 5'd1;
      expected_buckets.push_back(rec);
      return;
    end
    // z outermost, then y, then x; drop cells off the grid
    for (int dz = -1; dz <= 1; dz++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if (cz + dz >= 0 && cz + dz <= maxi && cy + dy >= 0 && cy + dy <= maxi &&
              cx + dx >= 0 && cx + dx <= maxi) begin
            rec.bucket = morton_bucket(cx + dx, cy + dy, cz + dz);
            rec.last   = 1'b0;
            rec.count  = '0;
            walk.push_back(rec);
          end
        end
      end
    end
    n = walk.size();
    if (n > 0) begin
      walk[n-1].last  = 1'b1;
      walk[n-1].count = n[COUNT_W-1:0];
    end
    foreach (walk[i]) expected_buckets.push_back(walk[i]);
  endfunction

  function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_total++;
    if (mismatch_total <= 10)
      $display("%t bucket item %s: expected bucket %0d last %0b count %0d, got bucket %0d last %0b count %0d",
               $realtime, what, want.bucket, want.last, want.count,
               got.bucket, got.last, got.count);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_size_q <= INV_RESET;
      expected_buckets.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) inv_size_q <= cfg_wdata_i;
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_item.bucket = m_axis_tdata_i[BUCKET_W-1:0];
        got_item.count  = m_axis_tdata_i[BUCKET_W+COUNT_W-1:BUCKET_W];
        got_item.last   = m_axis_tlast_i;
        if (expected_buckets.size() == 0) begin
          want_item = '0;
          note_mismatch("with nothing expected", want_item, got_item);
        end else begin
          want_item = expected_buckets.pop_front();
          if (got_item.bucket !== want_item.bucket || got_item.last !== want_item.last ||
              got_item.count !== want_item.count)
            note_mismatch("differs", want_item, got_item);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_buckets(s_axis_tuser_i, s_axis_tdata_i, inv_size_q);
      pending_o <= expected_buckets.size();
      errors_o  <= mismatch_total;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: neighbor cell bucket enumerator
// Drives directed corner positions and register values, then random phases
// with changing inverse cell sizes and idle patterns on both streams, and a
// long output hold that backs the block up. The checker judges every bucket.
// ----------------------------------------------------------------------------
module testbench;
  import ncbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int HOLD_CYCLES    = 200;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [INV_W-1:0]     cfg_wdata = '0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data = '0;   // pos_x, pos_y, pos_z
  logic                 s_action = 1'b0;
  logic                 m_valid;
  logic                 rx_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;        // bucket, bucket_count, pad
  logic                 m_last;

  int   errors;
  int   pending;
  int   send_idle = 9;
  int   recv_idle = 72;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   quiet_cycles = 0;
  logic [INV_W-1:0] inv_now = INV_RESET;

  always #4 clk_i = ~clk_i;

  neighbor_cell_bucket_enumerator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_action),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(rx_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  ncbe_bucket_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_action),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(rx_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tlast_i (m_last),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // receiver: random stalls, plus one long hold once requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          rx_ready <= 1'b0;
          @(posedge clk_i);
        end
        hold_done = 1'b1;
      end else begin
        rx_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && rx_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_item(logic action, logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid  <= 1'b1;
    s_action <= action;
    s_data   <= {pz, py, px};
    do @(posedge clk_i); while (!s_ready);
  endtask

  // drain every expected bucket, settle, then write the register
  task automatic set_inv(logic [INV_W-1:0] value);
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    inv_now = value;
  endtask

  function automatic logic [INV_W-1:0] pick_inv();
    case ($urandom_range(5))
      0:       return 16'($urandom_range(255));
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(511, 256));
      3:       return 16'($urandom_range(4095, 256));
      4:       return 16'($urandom_range(65535));
      default: return INV_RESET;
    endcase
  endfunction

  // mix of full-range values, extremes and points next to a cell edge
  function automatic logic [15:0] pick_pos(logic [INV_W-1:0] inv);
    longint edge_pos;
    int     k;
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: begin
        if (inv == 0) return 16'($urandom);
        k = $urandom_range(inv[15:8]);
        edge_pos = ((longint'(k) << 24) + inv - 1) / inv + $urandom_range(2) - 1;
        if (edge_pos < 0) edge_pos = 0;
        if (edge_pos > 65535) edge_pos = 65535;
        return 16'(edge_pos);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(int items, int hold_at);
    for (int seg = 0; seg < 3; seg++) begin
      set_inv(pick_inv());
      for (int i = 0; i < items / 3; i++) begin
        if (seg == 0 && i == hold_at) hold_req <= 1'b1;
        send_item(1'($urandom), pick_pos(inv_now), pick_pos(inv_now), pick_pos(inv_now));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register value of 10.0
    send_item(1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 16'h8000, 16'h8000, 16'h8000);
    send_item(1'b1, 16'h0000, 16'hFFFF, 16'h8000);
    send_item(1'b1, 16'h1999, 16'h199A, 16'h1999);
    // register below 256: a single cell
    set_inv(16'd255);
    send_item(1'b1, 16'hFFFF, 16'h8000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_inv(16'd0);
    send_item(1'b1, 16'h1234, 16'hABCD, 16'h5A5A);
    // largest grid: masked indices alias into shared buckets
    set_inv(16'hFFFF);
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'h0000, 16'hAAAA);
    send_item(1'b1, 16'h2000, 16'h4000, 16'h6000);
    send_item(1'b1, 16'h5555, 16'hAAAA, 16'h0F0F);
    // two cells per axis
    set_inv(16'd256);
    send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_item(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);

    run_phase(90, -1);
    send_idle = 72;
    recv_idle = 9;
    run_phase(90, -1);
    send_idle = 0;
    recv_idle = 0;
    run_phase(90, 5);

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== neighbor_cell_bucket_enumerator.f =====
hw/rtl/ncbe_pkg.sv
hw/rtl/ncbe_cell_mul.sv
hw/rtl/ncbe_seq.sv
hw/rtl/neighbor_cell_bucket_enumerator.sv
test/ncbe_bucket_checker.sv
test/testbench.sv
